// ===== sv/otsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Otsu threshold binarizer.
// No dependencies; used by every module of the block.
package otsu_pkg;

   localparam int BIN_COUNT = 256;
   localparam int GRAY_W    = 8;
   localparam int MEAN_W    = 24;   // Q8.16 class mean
   localparam int SQ_W      = 48;   // squared mean difference
   localparam int VAR_W     = 64;   // between-class variance
   localparam int VAR_SHIFT = 24;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;

   localparam logic [GRAY_W-1:0] LAST_BIN  = 8'hFF;
   localparam logic [GRAY_W-1:0] PIX_HIGH  = 8'hFF;
   localparam logic [GRAY_W-1:0] PIX_LOW   = 8'h00;
   localparam logic [MEAN_W-1:0] MEAN_MAX  = 24'hFFFFFF;

   localparam logic CMD_COLLECT  = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;
   localparam logic KIND_THRESH  = 1'b0;
   localparam logic KIND_PIXEL   = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [GRAY_W-1:0] gray;
      logic              last;
   } item_type;

   // head of the front queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // back end control returned to the front
   typedef struct packed {
      logic pop;
      logic init_done;
   } ctrl_type;

endpackage

// ===== sv/otsu_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request beats into a short queue for the back end.
// Depends on otsu_pkg.
module otsu_front
   import otsu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [GRAY_W-1:0] req_gray,
   input  logic              req_last,
   input  ctrl_type          ctrl,
   output head_type          head
);

   item_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     cnt_ff, cnt_in;
   logic                    push;
   logic                    pop;

   // no beats taken while the histogram is being cleared after reset
   assign req_ready = (cnt_ff != FIFO_PTR_W'(0) + (FIFO_PTR_W+1)'(FIFO_DEPTH))
                      && ctrl.init_done;
   assign push = req_valid && req_ready;
   assign pop  = ctrl.pop && (cnt_ff != '0);

   assign head.valid = (cnt_ff != '0);
   assign head.item  = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{cmd: req_cmd, gray: req_gray, last: req_last};
      end
   end

endmodule

// ===== sv/otsu_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider for the Q8.16 class means, one bit per cycle.
// Depends on otsu_pkg.
module otsu_div
   import otsu_pkg::*;
#(
   parameter int NUM_W = 37,
   parameter int DEN_W = 29
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              busy,
   output logic              done,
   output logic [MEAN_W-1:0] quot
);

   localparam int CNT_W = $clog2(MEAN_W + 1);

   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [MEAN_W-1:0] sh_ff, sh_in;
   logic [MEAN_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  num_hi;
   logic              sat;
   logic [DEN_W:0]    trial;
   logic              ge;

   // integer part above 255 saturates the mean
   assign num_hi = num >> GRAY_W;
   assign sat    = num_hi >= NUM_W'(den);
   assign trial  = {rem_ff, sh_ff[MEAN_W-1]};
   assign ge     = trial >= {1'b0, den_ff};

   always_comb begin
      den_in  = den_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         den_in = den;
         rem_in = DEN_W'(num_hi);
         sh_in  = {num[GRAY_W-1:0], {(MEAN_W-GRAY_W){1'b0}}};
         q_in   = sat ? MEAN_MAX : '0;
         cnt_in = CNT_W'(MEAN_W);
         busy_in = !sat;
         done_in = sat;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         sh_in  = {sh_ff[MEAN_W-2:0], 1'b0};
         q_in   = {q_ff[MEAN_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== sv/otsu_back.sv =====
`timescale 1ns / 1ps
// Back end: histogram memory, frame totals, Otsu search sequencer and the
// result register. Depends on otsu_pkg and otsu_div.
module otsu_back
   import otsu_pkg::*;
#(
   parameter int COUNT_BITS = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  head_type          head,
   output ctrl_type          ctrl,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [GRAY_W-1:0] rsp_value
);

   localparam int CB     = COUNT_BITS;
   localparam int WB_W   = CB + GRAY_W;
   localparam int SB_W   = CB + 2 * GRAY_W;
   localparam int PW_RAW = 2 * CB + GRAY_W + SQ_W;
   localparam int SAT_LO = VAR_W + VAR_SHIFT;
   localparam int PROD_W = (PW_RAW > SAT_LO) ? PW_RAW : SAT_LO + 1;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_UPD    = 4'd2;
   localparam logic [3:0] S_SRD    = 4'd3;
   localparam logic [3:0] S_SACC   = 4'd4;
   localparam logic [3:0] S_SCHK   = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_SQ     = 4'd7;
   localparam logic [3:0] S_MULA   = 4'd8;
   localparam logic [3:0] S_MULB   = 4'd9;
   localparam logic [3:0] S_CMP    = 4'd10;
   localparam logic [3:0] S_NEXT   = 4'd11;
   localparam logic [3:0] S_REPORT = 4'd12;

   logic [CB-1:0]      hist_mem [BIN_COUNT];
   logic [CB-1:0]      hist_rd_ff;
   logic [GRAY_W-1:0]  mem_ra;
   logic               mem_we;
   logic [GRAY_W-1:0]  mem_wa;
   logic [CB-1:0]      mem_wd;

   logic [3:0]         state_ff, state_in;
   logic [GRAY_W-1:0]  idx_ff, idx_in;
   logic [GRAY_W-1:0]  gray_ff, gray_in;
   logic               last_ff, last_in;
   logic [CB-1:0]      pt_ff, pt_in;
   logic [WB_W-1:0]    it_ff, it_in;
   logic [WB_W-1:0]    wb_ff, wb_in;
   logic [SB_W-1:0]    sb_ff, sb_in;
   logic [VAR_W-1:0]   best_ff, best_in;
   logic [GRAY_W-1:0]  thr_ff, thr_in;
   logic [GRAY_W-1:0]  cur_thr_ff, cur_thr_in;
   logic [MEAN_W-1:0]  d_ff, d_in;
   logic [SQ_W-1:0]    d2_ff, d2_in;
   logic [PROD_W-1:0]  mcand_ff, mcand_in;
   logic [SQ_W-1:0]    mplier_ff, mplier_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [GRAY_W-1:0]  rsp_value_ff, rsp_value_in;

   logic               out_free;
   logic               pop;
   logic               div_start;
   logic [WB_W-1:0]    pt_ext;
   logic [WB_W-1:0]    wf;
   logic [SB_W-1:0]    it_ext;
   logic [SB_W-1:0]    sf;
   logic [WB_W:0]      it_sum;
   logic [WB_W-1:0]    bin_prod;
   logic [VAR_W-1:0]   var_val;
   logic               b_busy, b_done, f_busy, f_done;
   logic [MEAN_W-1:0]  mb, mf;

   // foreground weight and intensity, floored at zero
   assign pt_ext  = WB_W'(pt_ff);
   assign wf      = (pt_ext > wb_ff) ? pt_ext - wb_ff : '0;
   assign it_ext  = SB_W'(it_ff);
   assign sf      = (it_ext > sb_ff) ? it_ext - sb_ff : '0;
   assign it_sum  = {1'b0, it_ff} + (WB_W+1)'(gray_ff);
   assign bin_prod = WB_W'(idx_ff) * WB_W'(hist_rd_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // variance saturates to 64 bits
   assign var_val = (acc_ff[PROD_W-1:SAT_LO] != '0) ? '1
                                                  : acc_ff[SAT_LO-1:VAR_SHIFT];

   otsu_div #(.NUM_W(SB_W), .DEN_W(WB_W)) u_div_bg (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sb_ff),
      .den   (wb_ff),
      .busy  (b_busy),
      .done  (b_done),
      .quot  (mb)
   );

   otsu_div #(.NUM_W(SB_W), .DEN_W(WB_W)) u_div_fg (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sf),
      .den   (wf),
      .busy  (f_busy),
      .done  (f_done),
      .quot  (mf)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      gray_in      = gray_ff;
      last_in      = last_ff;
      pt_in        = pt_ff;
      it_in        = it_ff;
      wb_in        = wb_ff;
      sb_in        = sb_ff;
      best_in      = best_ff;
      thr_in       = thr_ff;
      cur_thr_in   = cur_thr_ff;
      d_in         = d_ff;
      d2_in        = d2_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = '0;
      mem_ra       = (state_ff == S_SRD) ? idx_ff : head.item.gray;

      unique case (state_ff)
         S_INIT: begin
            // clearing pass over the histogram after reset
            mem_we = 1'b1;
            idx_in = idx_ff + GRAY_W'(1);
            if (idx_ff == LAST_BIN) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               if (head.item.cmd == CMD_CLASSIFY) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_PIXEL;
                     rsp_value_in = (head.item.gray > cur_thr_ff) ? PIX_HIGH : PIX_LOW;
                  end
               end else begin
                  pop      = 1'b1;
                  gray_in  = head.item.gray;
                  last_in  = head.item.last;
                  state_in = S_UPD;
               end
            end
         end
         S_UPD: begin
            // saturating bin, count and intensity updates
            mem_we = 1'b1;
            mem_wa = gray_ff;
            mem_wd = (hist_rd_ff == '1) ? hist_rd_ff : hist_rd_ff + CB'(1);
            pt_in  = (pt_ff == '1) ? pt_ff : pt_ff + CB'(1);
            it_in  = it_sum[WB_W] ? '1 : it_sum[WB_W-1:0];
            if (last_ff) begin
               idx_in   = '0;
               wb_in    = '0;
               sb_in    = '0;
               best_in  = '0;
               thr_in   = '0;
               state_in = S_SRD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SRD: begin
            state_in = S_SACC;
         end
         S_SACC: begin
            // accumulate this bin and clear it behind the search
            wb_in    = wb_ff + WB_W'(hist_rd_ff);
            sb_in    = sb_ff + SB_W'(bin_prod);
            mem_we   = 1'b1;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (wb_ff == '0 || wf == '0) begin
               state_in = S_NEXT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (b_done && f_done) begin
               d_in     = (mb > mf) ? mb - mf : mf - mb;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            d2_in     = SQ_W'(d_ff) * SQ_W'(d_ff);
            mcand_in  = PROD_W'(wb_ff);
            mplier_in = SQ_W'(wf);
            acc_in    = '0;
            state_in  = S_MULA;
         end
         S_MULA: begin
            // shift-add for wb * wf
            if (mplier_ff == '0) begin
               mcand_in  = acc_ff;
               mplier_in = d2_ff;
               acc_in    = '0;
               state_in  = S_MULB;
            end else begin
               acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         S_MULB: begin
            // shift-add for (wb * wf) * d^2
            if (mplier_ff == '0) begin
               state_in = S_CMP;
            end else begin
               acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         S_CMP: begin
            if (var_val > best_ff) begin
               best_in = var_val;
               thr_in  = idx_ff;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (idx_ff == LAST_BIN) begin
               state_in = S_REPORT;
            end else begin
               idx_in   = idx_ff + GRAY_W'(1);
               state_in = S_SRD;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_THRESH;
               rsp_value_in = thr_ff;
               cur_thr_in   = thr_ff;
               pt_in        = '0;
               it_in        = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
            idx_in   = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         pt_ff        <= '0;
         it_ff        <= '0;
         cur_thr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pt_ff        <= pt_in;
         it_ff        <= it_in;
         cur_thr_ff   <= cur_thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      gray_ff      <= gray_in;
      last_ff      <= last_in;
      wb_ff        <= wb_in;
      sb_ff        <= sb_in;
      best_ff      <= best_in;
      thr_ff       <= thr_in;
      d_ff         <= d_in;
      d2_ff        <= d2_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   // histogram memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_wa] <= mem_wd;
      end
      hist_rd_ff <= hist_mem[mem_ra];
   end

   assign ctrl.pop       = pop;
   assign ctrl.init_done = (state_ff != S_INIT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_value      = rsp_value_ff;

   // no result beat while the clearing pass runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !rsp_valid_ff)
      else $error("result beat during clearing pass");

   // the search walks the bins one at a time
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT && idx_ff != LAST_BIN) |=> (idx_ff == $past(idx_ff) + GRAY_W'(1)))
      else $error("search index skipped a bin");

   // both mean dividers are running or finished while waited on
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> ((b_busy || b_done) && (f_busy || f_done)))
      else $error("mean divider not started");

endmodule

// ===== sv/otsu_threshold_binarizer.sv =====
`timescale 1ns / 1ps
// Otsu threshold binarizer: collect pass builds a 256-bin histogram, the
// beat marked last starts the threshold search and a threshold report beat;
// classify beats return 0 or 255 against the stored threshold. A classify
// beat is answered once the result register is free; a collect beat is
// a read-modify-write on the histogram memory (read in S_IDLE, written in
// S_UPD); a four-entry queue decouples the request side from that work.
// The search visits every bin through S_SRD, S_SACC, S_SCHK and S_NEXT
// when a class is empty and otherwise also through the two 24-bit mean
// divisions, the squaring, the compare and the shift-add variance
// multiplier over the significant bits of wf and of d^2. After reset a
// clearing pass runs over all 256 histogram bins before req_ready rises.
// Depends on otsu_pkg, otsu_front, otsu_back and otsu_div.
module otsu_threshold_binarizer
   import otsu_pkg::*;
#(
   parameter int COUNT_BITS = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [GRAY_W-1:0] req_gray,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [GRAY_W-1:0] rsp_value
);

   head_type head;
   ctrl_type ctrl;

   otsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_gray  (req_gray),
      .req_last  (req_last),
      .ctrl      (ctrl),
      .head      (head)
   );

   otsu_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .ctrl      (ctrl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_kind  (rsp_kind),
      .rsp_value (rsp_value)
   );

endmodule

// ===== bench/tb_otsu_threshold_binarizer.sv =====
`timescale 1ns / 1ps
// Self-checking bench for otsu_threshold_binarizer: a directed table, then random
// frames, with random idling on both sides. A local Otsu model predicts each beat.
// Depends on otsu_pkg and the block RTL.
module tb_otsu_threshold_binarizer
   import otsu_pkg::*;
;

   localparam int COUNT_BITS = 21;
   localparam longint unsigned CNT_MAX  = (64'd1 << COUNT_BITS) - 1;
   localparam longint unsigned SUM_MAX  = (64'd1 << (COUNT_BITS + 8)) - 1;
   localparam longint unsigned QMAX     = 64'hFFFFFF;
   localparam int CYCLE_LIMIT = 40000000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic              kind;
      logic [GRAY_W-1:0] value;
   } rsp_beat_type;

   typedef struct {
      logic              cmd;
      logic [GRAY_W-1:0] gray;
      logic              last;
      bit                typed;   // expected beat written in the row
      logic              kind;
      logic [GRAY_W-1:0] value;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = CMD_COLLECT;
   logic [GRAY_W-1:0] req_gray = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [GRAY_W-1:0] rsp_value;

   // histogram model
   longint unsigned hist_bins [BIN_COUNT];
   longint unsigned pix_count;
   longint unsigned gray_sum;
   logic [GRAY_W-1:0] cur_thresh;

   rsp_beat_type pending_rsp[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  send_burst = 0;
   bit  recv_burst = 0;
   dir_row_type dir_rows[$];

   otsu_threshold_binarizer #(.COUNT_BITS(COUNT_BITS)) u_top (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_gray, .req_last,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_value
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic log_mismatch(input string what);
      $display("mismatch @%0d: %s", cycle_count, what);
      fail_count++;
   endtask

   // Q8.16 mean, saturated
   function automatic longint unsigned class_mean(longint unsigned s, longint unsigned w);
      longint unsigned q, r;
      q = s / w;
      r = s % w;
      if (q > 255) return QMAX;
      return (q << 16) + ((r << 16) / w);
   endfunction

   // Otsu search over the model histogram
   function automatic logic [GRAY_W-1:0] otsu_pick();
      longint unsigned wb, sb, wf, sf, mb, mf, d, v, best;
      logic [127:0] prod;
      logic [GRAY_W-1:0] thr;
      best = 0; thr = '0; wb = 0; sb = 0;
      for (int i = 0; i < BIN_COUNT; i++) begin
         wb += hist_bins[i];
         sb += longint'(i) * hist_bins[i];
         wf = (pix_count > wb) ? pix_count - wb : 0;
         if (wb == 0 || wf == 0) continue;
         sf = (gray_sum > sb) ? gray_sum - sb : 0;
         mb = class_mean(sb, wb);
         mf = class_mean(sf, wf);
         d = (mb > mf) ? mb - mf : mf - mb;
         prod = 128'(wb) * 128'(wf) * 128'(d * d);
         v = (prod[127:88] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[87:24];
         if (v > best) begin
            best = v;
            thr = i[GRAY_W-1:0];
         end
      end
      return thr;
   endfunction

   // advance the model by one accepted beat; returns 1 when a result is due
   function automatic bit binarize_step(input logic cmd, input logic [GRAY_W-1:0] gray,
                                        input logic last, output rsp_beat_type beat);
      if (cmd == CMD_CLASSIFY) begin
         beat.kind = KIND_PIXEL;
         beat.value = (gray > cur_thresh) ? PIX_HIGH : PIX_LOW;
         return 1;
      end
      if (hist_bins[gray] < CNT_MAX) hist_bins[gray]++;
      if (pix_count < CNT_MAX) pix_count++;
      gray_sum = (gray_sum > SUM_MAX - gray) ? SUM_MAX : gray_sum + gray;
      if (!last) return 0;
      cur_thresh = otsu_pick();
      foreach (hist_bins[i]) hist_bins[i] = 0;
      pix_count = 0;
      gray_sum = 0;
      beat.kind = KIND_THRESH;
      beat.value = cur_thresh;
      return 1;
   endfunction

   // drive one beat after a random gap; typed expectation overrides the model
   task automatic send_beat(input logic cmd, input logic [GRAY_W-1:0] gray, input logic last,
                            input bit typed = 0, input logic kind = 1'b0,
                            input logic [GRAY_W-1:0] value = '0);
      int gap;
      rsp_beat_type beat;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_gray <= gray;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      if (binarize_step(cmd, gray, last, beat)) begin
         if (typed && (beat.kind !== kind || beat.value !== value))
            log_mismatch($sformatf("row expectation %0d/%0d vs model %0d/%0d",
                                   kind, value, beat.kind, beat.value));
         if (typed) begin
            beat.kind = kind;
            beat.value = value;
         end
         pending_rsp.push_back(beat);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, checked against the oldest expectation
   initial begin
      rsp_beat_type want;
      int stall;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
         stall = recv_burst ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_rsp.size() == 0)
            log_mismatch("result beat with nothing expected");
         else begin
            want = pending_rsp.pop_front();
            if (rsp_kind !== want.kind)
               log_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
            if (rsp_value !== want.value)
               log_mismatch($sformatf("value %0d, expected %0d", rsp_value, want.value));
         end
      end
   end

   // stimulus
   initial begin
      int sent, flen, lo, hi, spread;
      logic [GRAY_W-1:0] g;
      foreach (hist_bins[i]) hist_bins[i] = 0;
      pix_count = 0; gray_sum = 0; cur_thresh = '0;

      // classify before any search uses threshold 0
      dir_rows.push_back('{CMD_CLASSIFY, 8'd0,   1'b0, 1, KIND_PIXEL, PIX_LOW});
      dir_rows.push_back('{CMD_CLASSIFY, 8'd1,   1'b0, 1, KIND_PIXEL, PIX_HIGH});
      dir_rows.push_back('{CMD_CLASSIFY, 8'd255, 1'b0, 1, KIND_PIXEL, PIX_HIGH});
      // last during classify is ignored
      dir_rows.push_back('{CMD_CLASSIFY, 8'd0,   1'b1, 1, KIND_PIXEL, PIX_LOW});
      // empty frame: the last pixel alone
      dir_rows.push_back('{CMD_COLLECT,  8'd200, 1'b1, 1, KIND_THRESH, 8'd0});
      // single-level frame
      dir_rows.push_back('{CMD_COLLECT,  8'd128, 1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_COLLECT,  8'd128, 1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_COLLECT,  8'd128, 1'b1, 1, KIND_THRESH, 8'd0});
      // extremes 0 and 255
      dir_rows.push_back('{CMD_COLLECT,  8'd0,   1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_COLLECT,  8'd255, 1'b1, 1, KIND_THRESH, 8'd0});
      dir_rows.push_back('{CMD_CLASSIFY, 8'd255, 1'b0, 1, KIND_PIXEL, PIX_HIGH});
      // bimodal frame, threshold from the model
      dir_rows.push_back('{CMD_COLLECT,  8'd10,  1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_COLLECT,  8'd12,  1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_COLLECT,  8'd200, 1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_COLLECT,  8'd220, 1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_COLLECT,  8'd90,  1'b1, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_CLASSIFY, 8'd11,  1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_CLASSIFY, 8'd12,  1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_CLASSIFY, 8'd13,  1'b0, 0, 1'b0, 8'd0});
      dir_rows.push_back('{CMD_CLASSIFY, 8'd128, 1'b1, 0, 1'b0, 8'd0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].cmd, dir_rows[i].gray, dir_rows[i].last,
                   dir_rows[i].typed, dir_rows[i].kind, dir_rows[i].value);

      // hold off until the directed results are all back
      wait_drained();

      // random frames: collect with last, then classify beats, some noise
      sent = 0;
      while (sent < 1650) begin
         if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
         flen = $urandom_range(1, 30);
         lo = $urandom_range(0, 255);
         spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 60);
         hi = (lo + spread > 255) ? 255 : lo + spread;
         for (int k = 0; k < flen; k++) begin
            // two clusters or uniform noise
            case ($urandom_range(0, 2))
               0: g = GRAY_W'($urandom_range(lo, hi));
               1: g = GRAY_W'(255 - $urandom_range(lo, hi));
               default: g = GRAY_W'($urandom_range(0, 255));
            endcase
            send_beat(CMD_COLLECT, g, k == flen - 1);
            sent++;
         end
         repeat ($urandom_range(2, 20)) begin
            send_beat(CMD_CLASSIFY, GRAY_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            sent++;
         end
         // at random, hold off until every result is back
         if ($urandom_range(0, 9) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
